// ===== rtl/core/sha512_stream_hash_top_assert.svh =====
// Assertion macros for the SHA-512 stream hash unit
`ifndef SHA512_STREAM_HASH_TOP_ASSERT_SVH
`define SHA512_STREAM_HASH_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off during reset
`define SHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha512 stream hash assertion failed");

// Next-cycle implication, checked on clk_i, off during reset
`define SHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha512 stream hash assertion failed");

`endif

// ===== rtl/core/shs_pkg.sv =====
// Shared types, constants and functions of the SHA-512 stream hash unit
`timescale 1ns / 1ps
package shs_pkg;

  localparam int unsigned Rounds   = 80;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned LenWords = 14;   // words before the length field

  // word source for a push into the block window
  localparam logic [1:0] PUSH_PAD  = 2'd0;
  localparam logic [1:0] PUSH_ZERO = 2'd1;
  localparam logic [1:0] PUSH_LENH = 2'd2;
  localparam logic [1:0] PUSH_LENL = 2'd3;

  typedef struct packed {
    logic       absorb;
    logic       push;
    logic [1:0] push_sel;
    logic       comp_start;
    logic       msg_clear;
    logic [2:0] out_idx;
  } shs_cmd_t;

  typedef struct packed {
    logic [4:0] wcnt;
    logic       comp_done;
  } shs_stat_t;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] init_h(input logic [2:0] i);
    case (i)
      3'd0:    init_h = 64'h6a09e667f3bcc908;
      3'd1:    init_h = 64'hbb67ae8584caa73b;
      3'd2:    init_h = 64'h3c6ef372fe94f82b;
      3'd3:    init_h = 64'ha54ff53a5f1d36f1;
      3'd4:    init_h = 64'h510e527fade682d1;
      3'd5:    init_h = 64'h9b05688c2b3e6c1f;
      3'd6:    init_h = 64'h1f83d9abfb41bd6b;
      default: init_h = 64'h5be0cd19137e2179;
    endcase
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] t);
    case (t)
      7'd0:  round_k = 64'h428a2f98d728ae22;  7'd1:  round_k = 64'h7137449123ef65cd;
      7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;  7'd3:  round_k = 64'he9b5dba58189dbbc;
      7'd4:  round_k = 64'h3956c25bf348b538;  7'd5:  round_k = 64'h59f111f1b605d019;
      7'd6:  round_k = 64'h923f82a4af194f9b;  7'd7:  round_k = 64'hab1c5ed5da6d8118;
      7'd8:  round_k = 64'hd807aa98a3030242;  7'd9:  round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c;  7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f;  7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235;  7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2;  7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5;  7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275;  7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4;  7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab;  7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f;  7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2;  7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f;  7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc;  7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed;  7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de;  7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6;  7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364;  7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791;  7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218;  7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a;  7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8;  7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99;  7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63;  7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373;  7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc;  7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72;  7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28;  7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915;  7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c;  7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e;  7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba;  7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae;  7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84;  7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc;  7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6;  7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec;  7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = '0;
    endcase
  endfunction

endpackage

// ===== rtl/core/shs_ctrl.sv =====
// Sequencer of the SHA-512 stream hash unit: absorb, padding, compression, digest readout
`timescale 1ns / 1ps
module shs_ctrl
  import shs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      last_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      digest_last_o,
  output shs_cmd_t  cmd_o,
  input  shs_stat_t stat_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_PADW = 3'd2;
  localparam logic [2:0] ST_ZERO = 3'd3;
  localparam logic [2:0] ST_LENH = 3'd4;
  localparam logic [2:0] ST_LENL = 3'd5;
  localparam logic [2:0] ST_COMP = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic [2:0] idx_q, idx_d;

  // next state and datapath commands
  always_comb begin
    state_d        = state_q;
    ret_d          = ret_q;
    idx_d          = idx_q;
    cmd_o          = '0;
    cmd_o.out_idx  = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.absorb = 1'b1;
          ret_d        = last_i ? ST_PADW : ST_IDLE;
          state_d      = ST_CHK;
        end
      end
      ST_CHK: begin
        // a full block goes through compression before anything else
        if (stat_i.wcnt == 5'(BlkWords)) begin
          cmd_o.comp_start = 1'b1;
          state_d          = ST_COMP;
        end else begin
          state_d = ret_q;
        end
      end
      ST_PADW: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PUSH_PAD;
        ret_d          = ST_ZERO;
        state_d        = ST_CHK;
      end
      ST_ZERO: begin
        if (stat_i.wcnt == 5'(LenWords)) begin
          state_d = ST_LENH;
        end else begin
          cmd_o.push     = 1'b1;
          cmd_o.push_sel = PUSH_ZERO;
          ret_d          = ST_ZERO;
          state_d        = ST_CHK;
        end
      end
      ST_LENH: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PUSH_LENH;
        state_d        = ST_LENL;
      end
      ST_LENL: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PUSH_LENL;
        ret_d          = ST_OUT;
        state_d        = ST_CHK;
      end
      ST_COMP: begin
        if (stat_i.comp_done) begin
          state_d = ret_q;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (idx_q == 3'd7) begin
            cmd_o.msg_clear = 1'b1;
            idx_d           = '0;
            state_d         = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      idx_q   <= idx_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_last_o = (idx_q == 3'd7);

endmodule

// ===== rtl/core/shs_datapath.sv =====
// Datapath of the SHA-512 stream hash unit: byte packing, block window, rounds, hash state
`timescale 1ns / 1ps
module shs_datapath
  import shs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  output logic [63:0] digest_word_o,
  input  shs_cmd_t    cmd_i,
  output shs_stat_t   stat_o
);

  logic [63:0]  h_q [8];
  logic [63:0]  v_q [8];
  logic [63:0]  w_q [BlkWords];
  logic [4:0]   wcnt_q;
  logic [63:0]  acc_q;
  logic [2:0]   afill_q;
  logic [127:0] tot_q;
  logic         busy_q;
  logic [6:0]   rnd_q;

  // byte packing: partial word plus new bytes, left aligned
  logic [3:0]   cnt;
  logic [63:0]  dmask;
  logic [127:0] comb;
  logic [3:0]   sum;
  logic         done;
  always_comb begin
    cnt   = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
    dmask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {cnt, 3'b000});
    comb  = {acc_q, 64'b0} | ({data_word_i & dmask, 64'b0} >> {afill_q, 3'b000});
    sum   = {1'b0, afill_q} + cnt;
    done  = busy_q && (rnd_q == 7'(Rounds));
  end

  // word pushed into the block window
  logic [63:0] push_word;
  always_comb begin
    case (cmd_i.push_sel)
      PUSH_PAD:  push_word = acc_q | (64'h8000_0000_0000_0000 >> {afill_q, 3'b000});
      PUSH_ZERO: push_word = '0;
      PUSH_LENH: push_word = tot_q[124:61];
      PUSH_LENL: push_word = {tot_q[60:0], 3'b000};
      default:   push_word = '0;
    endcase
  end

  // one round and one schedule step
  logic [63:0] t1, t2, wnew, s0, s1;
  always_comb begin
    t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + w_q[0];
    t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    s0 = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
    s1 = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
    wnew = w_q[0] + s0 + w_q[9] + s1;
  end

  // block window, no reset needed
  always_ff @(posedge clk_i) begin
    if (busy_q && !done) begin
      for (int i = 0; i < BlkWords - 1; i++) w_q[i] <= w_q[i + 1];
      w_q[BlkWords - 1] <= wnew;
    end else if (cmd_i.push || (cmd_i.absorb && sum[3])) begin
      for (int i = 0; i < BlkWords - 1; i++) w_q[i] <= w_q[i + 1];
      w_q[BlkWords - 1] <= cmd_i.push ? push_word : comb[127:64];
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (busy_q && !done) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // hash state, counters and packing register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
      wcnt_q  <= '0;
      acc_q   <= '0;
      afill_q <= '0;
      tot_q   <= '0;
      busy_q  <= 1'b0;
      rnd_q   <= '0;
    end else begin
      if (cmd_i.msg_clear) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
        tot_q <= '0;
      end else if (done) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.comp_start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
        wcnt_q <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 7'd1;
      end
      if (cmd_i.absorb) begin
        tot_q <= tot_q + 128'(cnt);
        if (sum[3]) begin
          acc_q  <= comb[63:0];
          wcnt_q <= wcnt_q + 5'd1;
        end else begin
          acc_q <= comb[127:64];
        end
        afill_q <= sum[2:0];
      end else if (cmd_i.push) begin
        wcnt_q <= wcnt_q + 5'd1;
        if (cmd_i.push_sel == PUSH_PAD) begin
          acc_q   <= '0;
          afill_q <= '0;
        end
      end
    end
  end

  assign digest_word_o    = h_q[cmd_i.out_idx];
  assign stat_o.wcnt      = wcnt_q;
  assign stat_o.comp_done = done;

endmodule

// ===== rtl/core/sha512_stream_hash_top.sv =====
// Streaming SHA-512 hash unit, top level
// Takes big-endian 64-bit words with a byte count and a last flag, packs them into
// 128-byte blocks and runs the FIPS 180-4 compression one round per cycle: a check for a
// full block, then the 80 rounds and a fold of the result into the hash state. Each word is
// accepted and checked, and one that completes a block is compressed, before the next
// word is taken. The last word starts padding (the pad word, then zero fill words, plus a
// compression when the padded data runs past 112 bytes), the length words, the length
// block compression, then eight digest transfers, index 0 first. No input is taken while a
// message is being finalized or its digest read out; afterwards the unit is back in its
// reset state.
`timescale 1ns / 1ps
module sha512_stream_hash_top
  import shs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  digest_index_o,
  output logic        digest_last_o
);

  shs_cmd_t  cmd;
  shs_stat_t stat;

  shs_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .last_i,
    .out_valid_o,
    .out_ready_i,
    .digest_last_o,
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  shs_datapath u_dp (
    .clk_i,
    .rst_ni,
    .data_word_i,
    .byte_count_i,
    .digest_word_o,
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  assign digest_index_o = cmd.out_idx;

endmodule

// ===== rtl/core/shs_checker.sv =====
// Port-level checks of the SHA-512 stream hash unit, bound to the top level
`timescale 1ns / 1ps
`include "sha512_stream_hash_top_assert.svh"
module shs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] digest_word_o,
  input logic [2:0]  digest_index_o,
  input logic        digest_last_o
);

  // a stalled digest transfer holds its payload
  `SHS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(digest_word_o) && $stable(digest_index_o))
  // input and output never both open
  `SHS_ASSERT_IMP(a_one_side, out_valid_o, !in_ready_o)
  // an accepted word is processed before the next one
  `SHS_ASSERT_NXT(a_in_gap, in_valid_i && in_ready_o, !in_ready_o)
  // digest words come out in order
  `SHS_ASSERT_NXT(a_idx_step, out_valid_o && out_ready_i && !digest_last_o, out_valid_o && (digest_index_o == $past(digest_index_o) + 3'd1))
  // last flag marks exactly index seven
  `SHS_ASSERT_IMP(a_last_idx, out_valid_o, digest_last_o == (digest_index_o == 3'd7))

endmodule

bind sha512_stream_hash_top shs_checker u_shs_checker (.*);

// ===== tb/sv/sha512_stream_hash_checker.sv =====
// Digest checker for the SHA-512 stream hash unit: watches both channels, predicts, compares
`timescale 1ns / 1ps
module sha512_stream_hash_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] digest_word_i,
  input  logic [2:0]  digest_index_i,
  input  logic        digest_last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  localparam logic [63:0] InitH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  logic [63:0]  hash_q [8];
  logic [7:0]   blk_q [128];
  int unsigned  fill_q;
  logic [127:0] msg_bytes_q;
  digest_t      digest_q [$];
  int           fail_q;

  assign fail_count_o = fail_q;
  assign pending_o    = digest_q.size();

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // one compression of the current block into the hash state
  task automatic compress();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2;
    for (int t = 0; t < 16; t++)
      for (int b = 0; b < 8; b++) w[t] = {w[t][55:0], blk_q[t*8+b]};
    for (int t = 16; t < 80; t++)
      w[t] = w[t-16] + (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-7]
           + (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6));
    v = hash_q;
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endtask

  task automatic restart();
    hash_q = InitH;
    foreach (blk_q[i]) blk_q[i] = '0;
    fill_q = 0;
    msg_bytes_q = '0;
  endtask

  // absorb one input word; on the last word pad, finish and queue the digest
  task automatic absorb_word(input logic [63:0] data, input logic [3:0] cnt, input logic fin);
    int unsigned n;
    logic [127:0] bits;
    digest_t d;
    n = (cnt > 8) ? 8 : cnt;
    for (int i = 0; i < n; i++) begin
      blk_q[fill_q] = data[63-8*i -: 8];
      fill_q = (fill_q + 1) % 128;
      msg_bytes_q += 1;
      if (fill_q == 0) compress();
    end
    if (!fin) return;
    blk_q[fill_q] = 8'h80;
    fill_q++;
    for (int i = fill_q; i < 128; i++) blk_q[i] = '0;
    if (fill_q > 112) begin
      compress();
      foreach (blk_q[i]) blk_q[i] = '0;
    end
    bits = msg_bytes_q << 3;
    for (int b = 0; b < 16; b++) blk_q[112+b] = bits[127-8*b -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      d.word = hash_q[i];
      d.index = i[2:0];
      d.last = (i == 7);
      digest_q.push_back(d);
    end
    restart();
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("%0t: digest mismatch on %s: got %h expected %h", $realtime, what, got, exp);
    fail_q++;
  endtask

  initial begin
    fail_q = 0;
    restart();
  end

  // sample transfers at the clock edge
  always @(posedge clk_i) begin
    digest_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) absorb_word(data_word_i, byte_count_i, last_i);
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          report("unexpected transfer", digest_word_i, '0);
        end else begin
          e = digest_q.pop_front();
          if (digest_word_i !== e.word) report("word", digest_word_i, e.word);
          if (digest_index_i !== e.index) report("index", digest_index_i, e.index);
          if (digest_last_i !== e.last) report("last", digest_last_i, e.last);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_sha512_stream_hash_top.sv =====
// Testbench top for the SHA-512 stream hash unit: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_sha512_stream_hash_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] data_word_i = '0;
  logic [3:0]  byte_count_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] digest_word_o;
  logic [2:0]  digest_index_o;
  logic        digest_last_o;
  int          fail_count;
  int          pending;
  int          cycle_q = 0;

  localparam int CycleLimit = 1500000;

  always #10 clk_i = ~clk_i;

  sha512_stream_hash_top dut (.*);

  sha512_stream_hash_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .data_word_i, .byte_count_i,
    .last_i, .out_valid_i(out_valid_o), .out_ready_i, .digest_word_i(digest_word_o),
    .digest_index_i(digest_index_o), .digest_last_i(digest_last_o),
    .fail_count_o(fail_count), .pending_o(pending));

  // watchdog
  always @(posedge clk_i) begin
    cycle_q <= cycle_q + 1;
    if (cycle_q > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 2);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // receiver: random stall before each digest transfer, ready stays up when no stall
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // one input transfer after a random gap; valid drops only when a gap follows
  task automatic send_word(input logic [63:0] data, input logic [3:0] cnt, input logic fin,
                           input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_word_i  <= data;
    byte_count_i <= cnt;
    last_i       <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // message of a given byte length, full words with an occasional short one
  task automatic send_message(input int nbytes, input bit burst);
    int left;
    int c;
    left = nbytes;
    while (left > 8) begin
      c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : 8;
      if ($urandom_range(0, 19) == 0) c = $urandom_range(9, 15);
      send_word(rand64(), c[3:0], 1'b0, burst);
      left -= (c > 8) ? 8 : c;
    end
    send_word(rand64(), left[3:0], 1'b1, burst);
  endtask

  initial begin
    int words_sent;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, field extremes, saturation, padding boundaries
    send_word('0, 4'd0, 1'b1);
    send_word({64{1'b1}}, 4'd15, 1'b1);
    send_word(64'h6162630000000000, 4'd3, 1'b1);
    send_word('0, 4'd8, 1'b0);
    send_word({64{1'b1}}, 4'd0, 1'b0);
    send_word(64'h5555aaaa5555aaaa, 4'd9, 1'b1);
    send_message(111, 1'b1);
    send_message(112, 1'b0);
    send_message(127, 1'b0);
    send_message(128, 1'b1);
    words_sent = 70;

    // random messages, mostly short, few long
    while (words_sent < 370) begin
      int len;
      case ($urandom_range(0, 5))
        0:       len = $urandom_range(0, 8);
        1:       len = $urandom_range(105, 136);
        5:       len = $urandom_range(200, 400);
        default: len = $urandom_range(9, 100);
      endcase
      send_message(len, $urandom_range(0, 3) == 0);
      words_sent += len / 8 + 1;
    end
    in_valid_i <= 1'b0;

    // let the checker see the last transfer before draining
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/shs_pkg.sv
rtl/core/shs_ctrl.sv
rtl/core/shs_datapath.sv
rtl/core/sha512_stream_hash_top.sv
rtl/core/shs_checker.sv
tb/sv/sha512_stream_hash_checker.sv
tb/sv/tb_sha512_stream_hash_top.sv
